@@ rtl/ptl_pkg.sv @@
// Package for the profile_tier_level bit parser.
// Holds result types, element ids, position codes and the profile class table.
// No dependencies.
`default_nettype none
package ptl_pkg;

	localparam int MAX_SUB_LAYERS = 8;
	localparam int FIFO_DEPTH     = 4;
	localparam int NRULES         = 32;

	// position: bit 5 marks a sub-layer, bits 4:0 the syntax element
	localparam logic [5:0] POS_START = 6'd63;
	localparam logic [6:0] POS_DONE  = 7'd64;
	localparam logic [6:0] POS_SUB   = 7'd32;

	localparam logic [4:0] EL_SPACE    = 5'd0;
	localparam logic [4:0] EL_TIER     = 5'd1;
	localparam logic [4:0] EL_IDC      = 5'd2;
	localparam logic [4:0] EL_COMPAT   = 5'd3;
	localparam logic [4:0] EL_FLAG7    = 5'd7;
	localparam logic [4:0] EL_FLAG8    = 5'd8;
	localparam logic [4:0] EL_FLAG15   = 5'd15;
	localparam logic [4:0] EL_FLAG16   = 5'd16;
	localparam logic [4:0] EL_FLAG17   = 5'd17;
	localparam logic [4:0] EL_RESV     = 5'd18;
	localparam logic [4:0] EL_RESV7    = 5'd19;
	localparam logic [4:0] EL_INBLD    = 5'd20;
	localparam logic [4:0] EL_RESV1    = 5'd21;
	localparam logic [4:0] EL_CLASS    = 5'd22;
	localparam logic [4:0] EL_LEVEL    = 5'd23;
	localparam logic [4:0] EL_SL_PROF  = 5'd24;
	localparam logic [4:0] EL_SL_LEVEL = 5'd25;
	localparam logic [4:0] EL_PAD      = 5'd26;
	localparam logic [4:0] EL_TRUNC    = 5'd27;

	localparam logic [0:0] REG_PROFILE_PRESENT = 1'd0;
	localparam logic [0:0] REG_SUB_LAYERS      = 1'd1;

	typedef struct packed {
		logic [4:0]  element_id;
		logic [2:0]  layer;
		logic [42:0] value;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [6:0] pos;
		logic [2:0] idx;
	} seek_t;

	localparam logic [4:0] RULE_IDC [NRULES] = '{
		5'd2,
		5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4,
		5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4,
		5'd5, 5'd5, 5'd5, 5'd5,
		5'd7, 5'd7,
		5'd9, 5'd9, 5'd9, 5'd9
	};
	localparam logic [9:0] RULE_MASK [NRULES] = '{
		10'h080,
		10'h1FF, 10'h1FF, 10'h1FF, 10'h1FF, 10'h1FF, 10'h1FF, 10'h1FF, 10'h1FF,
		10'h1FF, 10'h1FF,
		10'h0FF, 10'h0FF, 10'h0FF, 10'h0FF, 10'h0FF, 10'h0FF, 10'h0FF, 10'h0FF,
		10'h0FF, 10'h0FF, 10'h0FF,
		10'h3FF, 10'h3FF, 10'h3FF, 10'h2FF,
		10'h1FF, 10'h1FF,
		10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF
	};
	localparam logic [9:0] RULE_PAT [NRULES] = '{
		10'h080,
		10'h13F, 10'h13B, 10'h139, 10'h138, 10'h119, 10'h10B, 10'h109, 10'h107,
		10'h103, 10'h101,
		10'h05F, 10'h05B, 10'h059, 10'h04B, 10'h049, 10'h047, 10'h043, 10'h041,
		10'h040, 10'h0C7, 10'h0C0,
		10'h307, 10'h303, 10'h300, 10'h040,
		10'h11F, 10'h11B,
		10'h31F, 10'h31B, 10'h307, 10'h303
	};
	localparam logic [5:0] RULE_CLS [NRULES] = '{
		6'd3,
		6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14,
		6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
		6'd27, 6'd28, 6'd29, 6'd30,
		6'd33, 6'd34,
		6'd37, 6'd38, 6'd39, 6'd40
	};
	localparam logic [5:0] CLASS_DEFAULT [32] = '{
		6'd0, 6'd1, 6'd2, 6'd4, 6'd26, 6'd31, 6'd32, 6'd35,
		6'd36, 6'd41, 6'd0, 6'd42, 6'd43, 6'd44, 6'd0, 6'd0,
		6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
		6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0
	};

	// first matching rule wins, else the default for the idc; a nonzero space gives class 0
	function automatic logic [5:0] profile_class(input logic [1:0] space,
			input logic [4:0] idc, input logic [9:0] cb);
		logic [5:0] r;
		logic       hit;
		r   = CLASS_DEFAULT[idc];
		hit = 1'b0;
		for (int i = 0; i < NRULES; i++) begin
			if (!hit && RULE_IDC[i] == idc && (cb & RULE_MASK[i]) == RULE_PAT[i]) begin
				r   = RULE_CLS[i];
				hit = 1'b1;
			end
		end
		if (space != 2'd0)
			r = 6'd0;
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/hevc_profile_tier_level_parser.sv @@
// Top level of the profile_tier_level bit parser: sequencer and result queue.
// Depends on ptl_pkg.
//
// Usage: one RBSP bit enters per item on the data channel (data_valid,
// data_stall, data_bit, buffer_end). Each finished syntax element leaves as
// one item on the result channel (result_valid, result_stall, element_id,
// layer, value, last). An item is taken when valid is high and stall low.
// Throughput is one bit per cycle while data_stall is low; the walk state
// updates in the cycle the bit is taken and its results land in a four-entry
// result queue, visible in the next cycle. A bit yields at most two results
// (reserved tail and profile class). data_stall rises when the queue holds
// more than two results, so a stalled receiver halts the input before the queue
// can overflow. buffer_end gives one truncation result and restarts the walk.
// Reset clears the walk to the start of a structure, empties the queue and
// sets profile_present to 1 and sub_layers_minus_one to 0. Registers are
// written through cfg_we, cfg_index and cfg_data with no handshake.
`default_nettype none
module hevc_profile_tier_level_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [2:0]  cfg_data,
	input  wire logic        data_valid,
	output logic             data_stall,
	input  wire logic        data_bit,
	input  wire logic        buffer_end,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [4:0]       element_id,
	output logic [2:0]       layer,
	output logic [42:0]      value,
	output logic             last
);

	logic       prof_present_q;
	logic [2:0] sl_minus1_q;

	logic [5:0]  pos_q, n_pos;
	logic [5:0]  bc_q, n_bc;
	logic [42:0] acc_q, n_acc;
	logic [31:0] compat_q, n_compat;
	logic [4:0]  idc_q, n_idc;
	logic [1:0]  space_q, n_space;
	logic [9:0]  cb_q, n_cb;
	logic [6:0]  ppb_q, n_ppb, lpb_q, n_lpb;
	logic [2:0]  idx_q, n_idx;

	ptl_pkg::result_t ent [2];
	logic [1:0]       k;
	logic             take;

	logic g_ext, g_14, g_m10, g_inbld;

	function automatic logic idc_or(input logic [31:0] set, input logic [4:0] idc,
			input logic [31:0] cf);
		return set[idc] || ((cf & set) != 32'd0);
	endfunction

	function automatic ptl_pkg::seek_t seek(input logic [3:0] from, input logic [2:0] n,
			input logic [6:0] ppb, input logic [6:0] lpb, input logic [2:0] cur);
		ptl_pkg::seek_t s;
		logic           found;
		s.pos = ptl_pkg::POS_DONE;
		s.idx = cur;
		found = 1'b0;
		for (int j = 0; j < ptl_pkg::MAX_SUB_LAYERS - 1; j++) begin
			if (!found && 4'(j) >= from && 3'(j) < n) begin
				if (ppb[j]) begin
					s.pos = ptl_pkg::POS_SUB;
					s.idx = 3'(j);
					found = 1'b1;
				end else if (lpb[j]) begin
					s.pos = ptl_pkg::POS_SUB | 7'(ptl_pkg::EL_LEVEL);
					s.idx = 3'(j);
					found = 1'b1;
				end
			end
		end
		return s;
	endfunction

	assign g_ext   = idc_or(32'h7F0, idc_q, compat_q);
	assign g_14    = idc_or(32'h620, idc_q, compat_q);
	assign g_m10   = idc_or(32'h004, idc_q, compat_q);
	assign g_inbld = idc_or(32'h23E, idc_q, compat_q);

	assign take = data_valid && !data_stall;

	// one bit of the walk
	always_comb begin
		logic [5:0]     cur;
		logic [4:0]     p;
		logic           sub;
		logic [2:0]     lay;
		logic [2:0]     tl;
		logic [5:0]     width;
		logic [6:0]     nxt;
		logic           adv;
		logic           rst;
		ptl_pkg::seek_t sk;

		n_pos = pos_q; n_bc = bc_q; n_acc = acc_q; n_compat = compat_q;
		n_idc = idc_q; n_space = space_q; n_cb = cb_q; n_ppb = ppb_q;
		n_lpb = lpb_q; n_idx = idx_q;
		ent[0] = '0; ent[1] = '0; k = 2'd0;
		nxt = 7'd0; adv = 1'b0; rst = 1'b0; tl = 3'd0; sk = '0;

		cur = (pos_q == ptl_pkg::POS_START) ? (prof_present_q ? 6'd0 : 6'(ptl_pkg::EL_LEVEL))
			: pos_q;
		p   = cur[4:0];
		sub = cur[5];
		lay = sub ? idx_q + 3'd1 : 3'd0;

		unique case (p)
			5'd0:  width = 6'd2;
			5'd2:  width = 6'd5;
			5'd3:  width = 6'd32;
			5'd18: width = g_ext ? (g_14 ? 6'd33 : 6'd34) : (g_m10 ? 6'd35 : 6'd43);
			5'd19: width = 6'd7;
			5'd23: width = 6'd8;
			5'd26: width = 6'd2;
			default: width = 6'd1;
		endcase

		if (buffer_end) begin
			if (pos_q != ptl_pkg::POS_START && (pos_q[5] || pos_q[4:0] == ptl_pkg::EL_SL_PROF
					|| pos_q[4:0] == ptl_pkg::EL_SL_LEVEL))
				tl = idx_q + 3'd1;
			ent[0] = '{ptl_pkg::EL_TRUNC, tl, 43'd0, 1'b1};
			k = 2'd1;
			rst = 1'b1;
		end else begin
			n_pos = cur;
			if (p == ptl_pkg::EL_COMPAT)
				n_compat = compat_q | (32'(data_bit) << bc_q[4:0]);
			else
				n_acc = {acc_q[41:0], data_bit};
			n_bc = bc_q + 6'd1;
			if (n_bc >= width) begin
				adv = 1'b1;
				k = 2'd1;
				ent[0] = '{p, lay, n_acc, 1'b0};
				unique case (p)
					5'd0: begin
						n_space = n_acc[1:0];
						nxt = {1'b0, sub, 5'd1};
					end
					5'd1: nxt = {1'b0, sub, 5'd2};
					5'd2: begin
						n_idc = n_acc[4:0];
						nxt = {1'b0, sub, 5'd3};
					end
					5'd3: begin
						ent[0].value = 43'(n_compat);
						nxt = {1'b0, sub, 5'd4};
					end
					5'd4, 5'd5, 5'd6: nxt = {1'b0, sub, p + 5'd1};
					5'd7: nxt = {1'b0, sub, g_ext ? ptl_pkg::EL_FLAG8
						: (g_m10 ? ptl_pkg::EL_RESV7 : ptl_pkg::EL_RESV)};
					5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17: begin
						n_cb = cb_q | (10'(n_acc[0]) << (p - 5'd8));
						priority case (p)
							ptl_pkg::EL_FLAG15: nxt = {1'b0, sub, g_ext ? ptl_pkg::EL_FLAG16
								: ptl_pkg::EL_RESV};
							ptl_pkg::EL_FLAG16: nxt = {1'b0, sub, g_14 ? ptl_pkg::EL_FLAG17
								: ptl_pkg::EL_RESV};
							ptl_pkg::EL_FLAG17: nxt = {1'b0, sub, ptl_pkg::EL_RESV};
							default: nxt = {1'b0, sub, p + 5'd1};
						endcase
					end
					5'd18: begin
						ent[1] = '{ptl_pkg::EL_CLASS, lay,
							43'(ptl_pkg::profile_class(space_q, idc_q, cb_q)), 1'b0};
						k = 2'd2;
						nxt = {1'b0, sub, ptl_pkg::EL_INBLD};
					end
					5'd19: nxt = {1'b0, sub, ptl_pkg::EL_FLAG15};
					5'd20: begin
						ent[0].element_id = g_inbld ? ptl_pkg::EL_INBLD : ptl_pkg::EL_RESV1;
						if (sub) begin
							if (lpb_q[idx_q]) begin
								nxt = ptl_pkg::POS_SUB | 7'(ptl_pkg::EL_LEVEL);
							end else begin
								sk = seek({1'b0, idx_q} + 4'd1, sl_minus1_q, ppb_q, lpb_q, idx_q);
								nxt = sk.pos;
								n_idx = sk.idx;
							end
						end else begin
							nxt = 7'(ptl_pkg::EL_LEVEL);
						end
					end
					5'd23: begin
						if (sub) begin
							sk = seek({1'b0, idx_q} + 4'd1, sl_minus1_q, ppb_q, lpb_q, idx_q);
							nxt = sk.pos;
							n_idx = sk.idx;
						end else if (sl_minus1_q == 3'd0) begin
							nxt = ptl_pkg::POS_DONE;
						end else begin
							n_idx = 3'd0;
							nxt = 7'(ptl_pkg::EL_SL_PROF);
						end
					end
					5'd24: begin
						if (sub) begin
							rst = 1'b1;
							k = 2'd0;
						end else begin
							n_ppb = ppb_q | (7'(n_acc[0]) << idx_q);
							ent[0].layer = idx_q + 3'd1;
							nxt = 7'(ptl_pkg::EL_SL_LEVEL);
						end
					end
					5'd25: begin
						if (sub) begin
							rst = 1'b1;
							k = 2'd0;
						end else begin
							n_lpb = lpb_q | (7'(n_acc[0]) << idx_q);
							ent[0].layer = idx_q + 3'd1;
							if ({1'b0, idx_q} + 4'd1 < {1'b0, sl_minus1_q}) begin
								n_idx = idx_q + 3'd1;
								nxt = 7'(ptl_pkg::EL_SL_PROF);
							end else begin
								n_idx = sl_minus1_q;
								nxt = 7'(ptl_pkg::EL_PAD);
							end
						end
					end
					5'd26: begin
						if (sub) begin
							rst = 1'b1;
							k = 2'd0;
						end else begin
							ent[0].layer = 3'd0;
							if (idx_q == 3'd7) begin
								sk = seek(4'd0, sl_minus1_q, n_ppb, n_lpb, idx_q);
								nxt = sk.pos;
								n_idx = sk.idx;
							end else begin
								n_idx = idx_q + 3'd1;
								nxt = 7'(ptl_pkg::EL_PAD);
							end
						end
					end
					default: begin
						rst = 1'b1;
						k = 2'd0;
					end
				endcase
				if (!rst) begin
					if (nxt == ptl_pkg::POS_DONE) begin
						if (k == 2'd2)
							ent[1].last = 1'b1;
						else
							ent[0].last = 1'b1;
						rst = 1'b1;
					end else begin
						n_pos = nxt[5:0];
						n_bc = 6'd0;
						n_acc = 43'd0;
						if (nxt[4:0] == 5'd0) begin
							n_compat = 32'd0; n_idc = 5'd0; n_space = 2'd0; n_cb = 10'd0;
						end
					end
				end
			end
		end

		if (rst) begin
			n_pos = ptl_pkg::POS_START; n_bc = 6'd0; n_acc = 43'd0; n_compat = 32'd0;
			n_idc = 5'd0; n_space = 2'd0; n_cb = 10'd0; n_ppb = 7'd0; n_lpb = 7'd0;
			n_idx = 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prof_present_q <= 1'b1;
			sl_minus1_q    <= 3'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptl_pkg::REG_PROFILE_PRESENT: prof_present_q <= cfg_data[0];
				ptl_pkg::REG_SUB_LAYERS:      sl_minus1_q    <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= ptl_pkg::POS_START; bc_q <= 6'd0; acc_q <= 43'd0; compat_q <= 32'd0;
			idc_q <= 5'd0; space_q <= 2'd0; cb_q <= 10'd0; ppb_q <= 7'd0; lpb_q <= 7'd0;
			idx_q <= 3'd0;
		end else if (take) begin
			pos_q <= n_pos; bc_q <= n_bc; acc_q <= n_acc; compat_q <= n_compat;
			idc_q <= n_idc; space_q <= n_space; cb_q <= n_cb; ppb_q <= n_ppb;
			lpb_q <= n_lpb; idx_q <= n_idx;
		end
	end

	// result queue
	ptl_pkg::result_t fifo_q [ptl_pkg::FIFO_DEPTH];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       pop;
	logic [1:0] push_n;

	assign pop    = result_valid && !result_stall;
	assign push_n = take ? k : 2'd0;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			fifo_q[wr_q] <= ent[0];
		if (push_n == 2'd2)
			fifo_q[wr_q + 2'd1] <= ent[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wr_q  <= wr_q + push_n;
			rd_q  <= rd_q + 2'(pop);
			cnt_q <= cnt_q + 3'(push_n) - 3'(pop);
		end
	end

	assign data_stall   = cnt_q > 3'd2;
	assign result_valid = cnt_q != 3'd0;
	assign element_id   = fifo_q[rd_q].element_id;
	assign layer        = fifo_q[rd_q].layer;
	assign value        = fifo_q[rd_q].value;
	assign last         = fifo_q[rd_q].last;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(ptl_pkg::FIFO_DEPTH))
		else $error("result queue overflow");
	a_trunc_restart: assert property (@(posedge clk) disable iff (!arst_n)
		take && buffer_end |=> pos_q == ptl_pkg::POS_START && cnt_q != 3'd0)
		else $error("truncation did not restart the walk");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(pos_q) && $stable(bc_q))
		else $error("walk moved without an item");

endmodule
`default_nettype wire
